/* rtl/hpc_pkg.sv */
package hpc_pkg;

   // field widths
   localparam int TEMP_W     = 19;
   localparam int ERR_W      = 20;
   localparam int INTEG_W    = 21;
   localparam int DUTY_W     = 10;
   localparam int GAIN_W     = 10;
   localparam int TARGET_W   = 18;
   localparam int LIMIT_W    = 20;
   localparam int SHIFT_W    = 4;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 20;

   // gain products are kept as magnitude plus sign
   localparam int PROD_W = 30;
   localparam int QUOT_W = 21;

   // x/1000 == (x>>3)/125; the /125 is a reciprocal multiply, exact for x>>3 < 2**27
   localparam int DIV_PRE    = 3;
   localparam int RECIP_W    = 28;
   localparam int DIV_SHIFT  = 34;
   localparam int DIV_PROD_W = PROD_W - DIV_PRE + RECIP_W;
   localparam logic [RECIP_W-1:0] DIV_RECIP = 28'd137438954;

   // register indexes on the csr port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET       = 4'd0,
      CSR_PROP_GAIN    = 4'd1,
      CSR_INTEG_GAIN   = 4'd2,
      CSR_INTEG_LIMIT  = 4'd3,
      CSR_DUTY_MIN     = 4'd4,
      CSR_DUTY_MAX     = 4'd5,
      CSR_DUTY_STEP    = 4'd6,
      CSR_SMOOTH_SHIFT = 4'd7
   } csr_index_type;

   // reset values of the registers
   localparam logic [TARGET_W-1:0] TARGET_RST       = 18'd40000;
   localparam logic [GAIN_W-1:0]   PROP_GAIN_RST    = 10'd25;
   localparam logic [GAIN_W-1:0]   INTEG_GAIN_RST   = 10'd2;
   localparam logic [LIMIT_W-1:0]  INTEG_LIMIT_RST  = 20'd180000;
   localparam logic [DUTY_W-1:0]   DUTY_MIN_RST     = 10'd0;
   localparam logic [DUTY_W-1:0]   DUTY_MAX_RST     = 10'd600;
   localparam logic [DUTY_W-1:0]   DUTY_STEP_RST    = 10'd50;
   localparam logic [SHIFT_W-1:0]  SMOOTH_SHIFT_RST = 4'd2;

   typedef struct packed {
      logic [TARGET_W-1:0] target_temp_mc;
      logic [GAIN_W-1:0]   prop_gain;
      logic [GAIN_W-1:0]   integ_gain;
      logic [LIMIT_W-1:0]  integral_limit;
      logic [DUTY_W-1:0]   duty_min;
      logic [DUTY_W-1:0]   duty_max;
      logic [DUTY_W-1:0]   duty_step;
      logic [SHIFT_W-1:0]  smooth_shift;
   } cfg_type;

   // magnitude / 1000, truncated
   function automatic logic [QUOT_W-1:0] div_by_1000(input logic [PROD_W-1:0] mag);
      logic [PROD_W-DIV_PRE-1:0] pre;
      logic [DIV_PROD_W-1:0]     prod;
      pre  = mag[PROD_W-1:DIV_PRE];
      prod = DIV_PROD_W'(pre) * DIV_PROD_W'(DIV_RECIP);
      return prod[DIV_SHIFT+QUOT_W-1:DIV_SHIFT];
   endfunction

endpackage

/* rtl/hpc_front_calc.sv */
// Smoothing filter, error and clamped integral update for one sample
module hpc_front_calc (
   input  hpc_pkg::cfg_type                   cfg,
   input  logic signed [hpc_pkg::TEMP_W-1:0]  sample,
   input  logic                               primed,
   input  logic signed [hpc_pkg::TEMP_W-1:0]  smoothed,
   input  logic signed [hpc_pkg::INTEG_W-1:0] integ,
   output logic signed [hpc_pkg::TEMP_W-1:0]  smoothed_new,
   output logic signed [hpc_pkg::ERR_W-1:0]   error_new,
   output logic signed [hpc_pkg::INTEG_W-1:0] integ_new
);

   logic signed [hpc_pkg::TEMP_W:0]    diff;
   logic signed [hpc_pkg::TEMP_W:0]    step;
   logic signed [hpc_pkg::TEMP_W:0]    filt_sum;
   logic signed [hpc_pkg::ERR_W-1:0]   half_err;
   logic signed [hpc_pkg::INTEG_W:0]   integ_sum;
   logic signed [hpc_pkg::INTEG_W:0]   lim_pos;
   logic signed [hpc_pkg::INTEG_W:0]   lim_neg;

   // first-order filter, floor shift of the difference
   always_comb begin
      diff     = $signed({sample[hpc_pkg::TEMP_W-1], sample})
               - $signed({smoothed[hpc_pkg::TEMP_W-1], smoothed});
      step     = diff >>> cfg.smooth_shift;
      filt_sum = $signed({smoothed[hpc_pkg::TEMP_W-1], smoothed}) + step;
      smoothed_new = primed ? filt_sum[hpc_pkg::TEMP_W-1:0] : sample;
   end

   // error against the setpoint
   assign error_new = $signed({2'b00, cfg.target_temp_mc})
                    - $signed({smoothed_new[hpc_pkg::TEMP_W-1], smoothed_new});

   // integral adds error/2 rounded toward zero, then symmetric clamp
   always_comb begin
      half_err  = (error_new + $signed({{(hpc_pkg::ERR_W-1){1'b0}},
                                        error_new[hpc_pkg::ERR_W-1]})) >>> 1;
      integ_sum = $signed({integ[hpc_pkg::INTEG_W-1], integ})
                + $signed({{(hpc_pkg::INTEG_W+1-hpc_pkg::ERR_W){half_err[hpc_pkg::ERR_W-1]}},
                           half_err});
      lim_pos   = $signed({2'b00, cfg.integral_limit});
      lim_neg   = -lim_pos;
      if (integ_sum < lim_neg) begin
         integ_new = lim_neg[hpc_pkg::INTEG_W-1:0];
      end else if (integ_sum > lim_pos) begin
         integ_new = lim_pos[hpc_pkg::INTEG_W-1:0];
      end else begin
         integ_new = integ_sum[hpc_pkg::INTEG_W-1:0];
      end
   end

endmodule

/* rtl/hpc_duty_calc.sv */
// PI sum, duty window clamp and slew limit against the previous duty
module hpc_duty_calc (
   input  hpc_pkg::cfg_type                 cfg,
   input  logic [hpc_pkg::QUOT_W-1:0]       p_quot,
   input  logic                             p_neg,
   input  logic [hpc_pkg::QUOT_W-1:0]       i_quot,
   input  logic                             i_neg,
   input  logic [hpc_pkg::DUTY_W-1:0]       last_duty,
   output logic [hpc_pkg::DUTY_W-1:0]       duty
);

   localparam int SUM_W = hpc_pkg::QUOT_W + 2;

   logic signed [SUM_W-1:0]         p_term;
   logic signed [SUM_W-1:0]         i_term;
   logic signed [SUM_W-1:0]         total;
   logic signed [SUM_W-1:0]         lo_bound;
   logic signed [SUM_W-1:0]         hi_bound;
   logic [hpc_pkg::DUTY_W-1:0]      clamped;
   logic [hpc_pkg::DUTY_W:0]        up_limit;
   logic [hpc_pkg::DUTY_W:0]        clamp_plus;

   // signed sum of the two terms
   always_comb begin
      p_term = $signed({2'b00, p_quot});
      i_term = $signed({2'b00, i_quot});
      if (p_neg) p_term = -p_term;
      if (i_neg) i_term = -i_term;
      total = p_term + i_term;
   end

   // window clamp, lower bound tested first
   always_comb begin
      lo_bound = $signed({{(SUM_W-hpc_pkg::DUTY_W){1'b0}}, cfg.duty_min});
      hi_bound = $signed({{(SUM_W-hpc_pkg::DUTY_W){1'b0}}, cfg.duty_max});
      if (total < lo_bound) begin
         clamped = cfg.duty_min;
      end else if (total > hi_bound) begin
         clamped = cfg.duty_max;
      end else begin
         clamped = total[hpc_pkg::DUTY_W-1:0];
      end
   end

   // slew limit
   always_comb begin
      up_limit   = {1'b0, last_duty} + {1'b0, cfg.duty_step};
      clamp_plus = {1'b0, clamped} + {1'b0, cfg.duty_step};
      if ({1'b0, clamped} > up_limit) begin
         duty = up_limit[hpc_pkg::DUTY_W-1:0];
      end else if ({1'b0, last_duty} > clamp_plus) begin
         duty = last_duty - cfg.duty_step;
      end else begin
         duty = clamped;
      end
   end

endmodule

/* rtl/heater_pi_controller.sv */
// Channel | Direction | Handshake            | Word
// req     | in        | req_valid/req_ready  | temp_sample_mc, sample_valid
// rsp     | out       | rsp_valid/rsp_ready  | heater_duty, filtered_temp_mc, temp_error_mc
// csr     | in        | csr_valid/csr_ready  | csr_index, csr_wdata (always ready)
//
// One word per cycle while rsp is not stalled; a result passes through the input reg,
// filter/integral stage, product stage, /1000 stage and result reg, in that order.
// Filter and integral state close their loop in one stage, last duty in the last.
// Reset clears all valids, the filter/integral/duty state and loads register defaults.
// A stalled rsp backs up stage by stage; req_ready drops only when every stage is full.
module heater_pi_controller (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [hpc_pkg::TEMP_W-1:0]    req_temp_sample_mc,
   input  logic                                 req_sample_valid,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [hpc_pkg::DUTY_W-1:0]           rsp_heater_duty,
   output logic signed [hpc_pkg::TEMP_W-1:0]    rsp_filtered_temp_mc,
   output logic signed [hpc_pkg::ERR_W-1:0]     rsp_temp_error_mc,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [hpc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [hpc_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   hpc_pkg::cfg_type cfg_ff, cfg_in;

   // stage valids
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic s4_valid_ff, s4_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic s1_go, s2_go, s3_go, s4_go;

   // loop state
   logic                                 primed_ff, primed_in;
   logic signed [hpc_pkg::TEMP_W-1:0]    smoothed_ff, smoothed_in;
   logic signed [hpc_pkg::INTEG_W-1:0]   integ_ff, integ_in;
   logic [hpc_pkg::DUTY_W-1:0]           last_duty_ff, last_duty_in;

   // stage payloads
   logic signed [hpc_pkg::TEMP_W-1:0]    s1_sample_ff;
   logic                                 s1_flag_ff;
   logic                                 s2_flag_ff;
   logic signed [hpc_pkg::TEMP_W-1:0]    s2_filt_ff;
   logic signed [hpc_pkg::ERR_W-1:0]     s2_err_ff;
   logic signed [hpc_pkg::INTEG_W-1:0]   s2_integ_ff;
   logic                                 s3_flag_ff;
   logic signed [hpc_pkg::TEMP_W-1:0]    s3_filt_ff;
   logic signed [hpc_pkg::ERR_W-1:0]     s3_err_ff;
   logic [hpc_pkg::PROD_W-1:0]           s3_pmag_ff, s3_pmag_in;
   logic [hpc_pkg::PROD_W-1:0]           s3_imag_ff, s3_imag_in;
   logic                                 s3_pneg_ff, s3_ineg_ff;
   logic                                 s4_flag_ff;
   logic signed [hpc_pkg::TEMP_W-1:0]    s4_filt_ff;
   logic signed [hpc_pkg::ERR_W-1:0]     s4_err_ff;
   logic [hpc_pkg::QUOT_W-1:0]           s4_pq_ff, s4_iq_ff;
   logic                                 s4_pneg_ff, s4_ineg_ff;
   logic [hpc_pkg::DUTY_W-1:0]           rsp_duty_ff, rsp_duty_in;
   logic signed [hpc_pkg::TEMP_W-1:0]    rsp_filt_ff;
   logic signed [hpc_pkg::ERR_W-1:0]     rsp_err_ff;

   logic signed [hpc_pkg::TEMP_W-1:0]    front_smoothed;
   logic signed [hpc_pkg::ERR_W-1:0]     front_error;
   logic signed [hpc_pkg::INTEG_W-1:0]   front_integ;
   logic [hpc_pkg::ERR_W-1:0]            err_abs;
   logic [hpc_pkg::INTEG_W-1:0]          integ_abs;
   logic [hpc_pkg::DUTY_W-1:0]           duty_calc;

   // configuration writes
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            hpc_pkg::CSR_TARGET:       cfg_in.target_temp_mc = csr_wdata[hpc_pkg::TARGET_W-1:0];
            hpc_pkg::CSR_PROP_GAIN:    cfg_in.prop_gain      = csr_wdata[hpc_pkg::GAIN_W-1:0];
            hpc_pkg::CSR_INTEG_GAIN:   cfg_in.integ_gain     = csr_wdata[hpc_pkg::GAIN_W-1:0];
            hpc_pkg::CSR_INTEG_LIMIT:  cfg_in.integral_limit = csr_wdata[hpc_pkg::LIMIT_W-1:0];
            hpc_pkg::CSR_DUTY_MIN:     cfg_in.duty_min       = csr_wdata[hpc_pkg::DUTY_W-1:0];
            hpc_pkg::CSR_DUTY_MAX:     cfg_in.duty_max       = csr_wdata[hpc_pkg::DUTY_W-1:0];
            hpc_pkg::CSR_DUTY_STEP:    cfg_in.duty_step      = csr_wdata[hpc_pkg::DUTY_W-1:0];
            hpc_pkg::CSR_SMOOTH_SHIFT: cfg_in.smooth_shift   = csr_wdata[hpc_pkg::SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline advance, each stage moves when the next is empty or moving
   always_comb begin
      s4_go = s4_valid_ff && (!rsp_valid_ff || rsp_ready);
      s3_go = s3_valid_ff && (!s4_valid_ff || s4_go);
      s2_go = s2_valid_ff && (!s3_valid_ff || s3_go);
      s1_go = s1_valid_ff && (!s2_valid_ff || s2_go);
      req_ready = !s1_valid_ff || s1_go;
   end

   always_comb begin
      s1_valid_in  = (req_valid && req_ready) ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
      s2_valid_in  = s1_go ? 1'b1 : (s2_go ? 1'b0 : s2_valid_ff);
      s3_valid_in  = s2_go ? 1'b1 : (s3_go ? 1'b0 : s3_valid_ff);
      s4_valid_in  = s3_go ? 1'b1 : (s4_go ? 1'b0 : s4_valid_ff);
      rsp_valid_in = s4_go ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // filter and integral, state moves only with a valid sample
   hpc_front_calc u_front (
      .cfg          (cfg_ff),
      .sample       (s1_sample_ff),
      .primed       (primed_ff),
      .smoothed     (smoothed_ff),
      .integ        (integ_ff),
      .smoothed_new (front_smoothed),
      .error_new    (front_error),
      .integ_new    (front_integ)
   );

   always_comb begin
      primed_in   = primed_ff;
      smoothed_in = smoothed_ff;
      integ_in    = integ_ff;
      if (s1_go && s1_flag_ff) begin
         primed_in   = 1'b1;
         smoothed_in = front_smoothed;
         integ_in    = front_integ;
      end
   end

   // gain products on magnitudes
   always_comb begin
      err_abs    = s2_err_ff[hpc_pkg::ERR_W-1] ? 20'(-s2_err_ff) : 20'(s2_err_ff);
      integ_abs  = s2_integ_ff[hpc_pkg::INTEG_W-1] ? 21'(-s2_integ_ff) : 21'(s2_integ_ff);
      s3_pmag_in = hpc_pkg::PROD_W'(cfg_ff.prop_gain) * hpc_pkg::PROD_W'(err_abs);
      s3_imag_in = hpc_pkg::PROD_W'(cfg_ff.integ_gain) * hpc_pkg::PROD_W'(integ_abs);
   end

   // duty and slew, last duty moves only with a valid sample
   hpc_duty_calc u_duty (
      .cfg       (cfg_ff),
      .p_quot    (s4_pq_ff),
      .p_neg     (s4_pneg_ff),
      .i_quot    (s4_iq_ff),
      .i_neg     (s4_ineg_ff),
      .last_duty (last_duty_ff),
      .duty      (duty_calc)
   );

   always_comb begin
      rsp_duty_in  = s4_flag_ff ? duty_calc : '0;
      last_duty_in = (s4_go && s4_flag_ff) ? duty_calc : last_duty_ff;
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_temp_mc <= hpc_pkg::TARGET_RST;
         cfg_ff.prop_gain      <= hpc_pkg::PROP_GAIN_RST;
         cfg_ff.integ_gain     <= hpc_pkg::INTEG_GAIN_RST;
         cfg_ff.integral_limit <= hpc_pkg::INTEG_LIMIT_RST;
         cfg_ff.duty_min       <= hpc_pkg::DUTY_MIN_RST;
         cfg_ff.duty_max       <= hpc_pkg::DUTY_MAX_RST;
         cfg_ff.duty_step      <= hpc_pkg::DUTY_STEP_RST;
         cfg_ff.smooth_shift   <= hpc_pkg::SMOOTH_SHIFT_RST;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         primed_ff    <= 1'b0;
         smoothed_ff  <= '0;
         integ_ff     <= '0;
         last_duty_ff <= '0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         s4_valid_ff  <= s4_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         primed_ff    <= primed_in;
         smoothed_ff  <= smoothed_in;
         integ_ff     <= integ_in;
         last_duty_ff <= last_duty_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_sample_ff <= req_temp_sample_mc;
         s1_flag_ff   <= req_sample_valid;
      end
      if (s1_go) begin
         s2_flag_ff  <= s1_flag_ff;
         s2_filt_ff  <= s1_flag_ff ? front_smoothed : '0;
         s2_err_ff   <= s1_flag_ff ? front_error : '0;
         s2_integ_ff <= front_integ;
      end
      if (s2_go) begin
         s3_flag_ff <= s2_flag_ff;
         s3_filt_ff <= s2_filt_ff;
         s3_err_ff  <= s2_err_ff;
         s3_pmag_ff <= s3_pmag_in;
         s3_imag_ff <= s3_imag_in;
         s3_pneg_ff <= s2_err_ff[hpc_pkg::ERR_W-1];
         s3_ineg_ff <= s2_integ_ff[hpc_pkg::INTEG_W-1];
      end
      if (s3_go) begin
         s4_flag_ff <= s3_flag_ff;
         s4_filt_ff <= s3_filt_ff;
         s4_err_ff  <= s3_err_ff;
         s4_pq_ff   <= hpc_pkg::div_by_1000(s3_pmag_ff);
         s4_iq_ff   <= hpc_pkg::div_by_1000(s3_imag_ff);
         s4_pneg_ff <= s3_pneg_ff;
         s4_ineg_ff <= s3_ineg_ff;
      end
      if (s4_go) begin
         rsp_duty_ff <= rsp_duty_in;
         rsp_filt_ff <= s4_filt_ff;
         rsp_err_ff  <= s4_err_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_heater_duty      = rsp_duty_ff;
   assign rsp_filtered_temp_mc = rsp_filt_ff;
   assign rsp_temp_error_mc    = rsp_err_ff;

endmodule

/* tb/sv/testbench.sv */
module testbench;

   localparam int REG_COUNT       = 8;
   localparam int PHASES          = 9;
   localparam int ITEMS_PER_PHASE = 185;
   localparam int LONG_HOLD       = 80;
   localparam int SETTLE_CYCLES   = 10;

   // one result word as the block returns it
   typedef struct packed {
      logic [hpc_pkg::DUTY_W-1:0]        duty;
      logic signed [hpc_pkg::TEMP_W-1:0] filt;
      logic signed [hpc_pkg::ERR_W-1:0]  err;
   } duty_word_type;

   // directed stimulus row; pinned rows carry their own expected word
   typedef struct packed {
      logic signed [hpc_pkg::TEMP_W-1:0] sample;
      logic                              ok;
      logic                              pinned;
      duty_word_type                     want;
   } stim_row_type;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic signed [hpc_pkg::TEMP_W-1:0] req_temp_sample_mc;
   logic                              req_sample_valid;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic [hpc_pkg::DUTY_W-1:0]        rsp_heater_duty;
   logic signed [hpc_pkg::TEMP_W-1:0] rsp_filtered_temp_mc;
   logic signed [hpc_pkg::ERR_W-1:0]  rsp_temp_error_mc;
   logic                              csr_valid;
   logic                              csr_ready;
   logic [hpc_pkg::CSR_IDX_W-1:0]     csr_index;
   logic [hpc_pkg::CSR_DATA_W-1:0]    csr_wdata;

   // travels with the sample word: use a typed-in expectation instead of the predictor
   logic          word_pinned;
   duty_word_type pinned_word;

   int tx_idle_pct = 10;
   int rx_idle_pct = 53;
   int holds_asked = 0;
   int holds_served = 0;
   int mismatches = 0;

   duty_word_type pending_duty[$];
   stim_row_type  directed_rows [22];

   // predictor state and its copy of the registers
   hpc_pkg::cfg_type ctl_cfg;
   longint  integ_sum;
   longint  smooth_mc;
   int unsigned prev_duty;
   bit      filter_loaded;

   heater_pi_controller dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_temp_sample_mc   (req_temp_sample_mc),
      .req_sample_valid     (req_sample_valid),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_heater_duty      (rsp_heater_duty),
      .rsp_filtered_temp_mc (rsp_filtered_temp_mc),
      .rsp_temp_error_mc    (rsp_temp_error_mc),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("testbench failed");
      $finish;
   end

   function automatic void clear_controller();
      ctl_cfg = '{hpc_pkg::TARGET_RST, hpc_pkg::PROP_GAIN_RST, hpc_pkg::INTEG_GAIN_RST,
                  hpc_pkg::INTEG_LIMIT_RST, hpc_pkg::DUTY_MIN_RST, hpc_pkg::DUTY_MAX_RST,
                  hpc_pkg::DUTY_STEP_RST, hpc_pkg::SMOOTH_SHIFT_RST};
      integ_sum     = 0;
      smooth_mc     = 0;
      prev_duty     = 0;
      filter_loaded = 1'b0;
   endfunction

   function automatic void load_register(input logic [hpc_pkg::CSR_IDX_W-1:0] idx,
                                         input logic [hpc_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         hpc_pkg::CSR_TARGET:       ctl_cfg.target_temp_mc = data[hpc_pkg::TARGET_W-1:0];
         hpc_pkg::CSR_PROP_GAIN:    ctl_cfg.prop_gain      = data[hpc_pkg::GAIN_W-1:0];
         hpc_pkg::CSR_INTEG_GAIN:   ctl_cfg.integ_gain     = data[hpc_pkg::GAIN_W-1:0];
         hpc_pkg::CSR_INTEG_LIMIT:  ctl_cfg.integral_limit = data[hpc_pkg::LIMIT_W-1:0];
         hpc_pkg::CSR_DUTY_MIN:     ctl_cfg.duty_min       = data[hpc_pkg::DUTY_W-1:0];
         hpc_pkg::CSR_DUTY_MAX:     ctl_cfg.duty_max       = data[hpc_pkg::DUTY_W-1:0];
         hpc_pkg::CSR_DUTY_STEP:    ctl_cfg.duty_step      = data[hpc_pkg::DUTY_W-1:0];
         hpc_pkg::CSR_SMOOTH_SHIFT: ctl_cfg.smooth_shift   = data[hpc_pkg::SHIFT_W-1:0];
         default: ;  // no register there, write dropped
      endcase
   endfunction

   // one control step: filter, PI law, duty clamp, slew limit
   function automatic duty_word_type predict_duty(
         input logic signed [hpc_pkg::TEMP_W-1:0] sample, input logic ok);
      duty_word_type w;
      longint        s, err, lim, drive, kp, ki, lo, hi, tgt;
      int unsigned   d, step;
      w = '0;
      if (!ok) return w;
      s = sample;
      if (!filter_loaded) begin
         smooth_mc     = s;
         filter_loaded = 1'b1;
      end else begin
         smooth_mc = smooth_mc + ((s - smooth_mc) >>> ctl_cfg.smooth_shift);
      end
      tgt = ctl_cfg.target_temp_mc;
      err = tgt - smooth_mc;
      // integral with symmetric clamp
      lim = ctl_cfg.integral_limit;
      integ_sum = integ_sum + (err * 500) / 1000;
      if (integ_sum < -lim)
         integ_sum = -lim;
      else if (integ_sum > lim)
         integ_sum = lim;
      kp = ctl_cfg.prop_gain;
      ki = ctl_cfg.integ_gain;
      drive = (kp * err) / 1000 + (ki * integ_sum) / 1000;
      // lower bound is tested first, so it wins when the window is inverted and drive is below it
      lo = ctl_cfg.duty_min;
      hi = ctl_cfg.duty_max;
      if (drive < lo)
         drive = lo;
      else if (drive > hi)
         drive = hi;
      d    = int'(drive);
      step = ctl_cfg.duty_step;
      if (d > prev_duty + step)
         d = prev_duty + step;
      else if (prev_duty > d + step)
         d = prev_duty - step;
      prev_duty = d & 32'h3FF;
      w.duty = d[hpc_pkg::DUTY_W-1:0];
      w.filt = smooth_mc[hpc_pkg::TEMP_W-1:0];
      w.err  = err[hpc_pkg::ERR_W-1:0];
      return w;
   endfunction

   // keep the register bits, fill the unused upper bits with noise
   function automatic logic [hpc_pkg::CSR_DATA_W-1:0] with_junk(
         input logic [hpc_pkg::CSR_DATA_W-1:0] v, input int w);
      logic [hpc_pkg::CSR_DATA_W-1:0] keep;
      keep = (hpc_pkg::CSR_DATA_W'(1) << w) - 1'b1;
      return (v & keep) | (hpc_pkg::CSR_DATA_W'($urandom) & ~keep);
   endfunction

   // response side: random stalls, plus long hold-offs on request
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served != holds_asked) begin
            holds_served++;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // watch all three channels, predict and compare
   always @(posedge clock) begin : watch
      duty_word_type got, want;
      if (reset) begin
         clear_controller();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_heater_duty, rsp_filtered_temp_mc, rsp_temp_error_mc};
            if (pending_duty.size() == 0) begin
               $display("%0t: result word with none expected: duty %0d filt %0d err %0d",
                        $time, got.duty, got.filt, got.err);
               mismatches++;
            end else begin
               want = pending_duty.pop_front();
               if (got.duty !== want.duty) begin
                  $display("%0t: heater_duty expected %0d actual %0d",
                           $time, want.duty, got.duty);
                  mismatches++;
               end
               if (got.filt !== want.filt) begin
                  $display("%0t: filtered_temp_mc expected %0d actual %0d",
                           $time, want.filt, got.filt);
                  mismatches++;
               end
               if (got.err !== want.err) begin
                  $display("%0t: temp_error_mc expected %0d actual %0d",
                           $time, want.err, got.err);
                  mismatches++;
               end
            end
         end
         if (csr_valid && csr_ready)
            load_register(csr_index, csr_wdata);
         if (req_valid && req_ready) begin
            want = predict_duty(req_temp_sample_mc, req_sample_valid);
            if (word_pinned)
               want = pinned_word;
            pending_duty.push_back(want);
         end
      end
   end

   task automatic send_sample(input logic signed [hpc_pkg::TEMP_W-1:0] sample, input logic ok,
                              input logic pin, input duty_word_type pin_word);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      req_valid          <= 1'b1;
      req_temp_sample_mc <= sample;
      req_sample_valid   <= ok;
      word_pinned        <= pin;
      pinned_word        <= pin_word;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop sending and wait out every pending result, then the pipeline
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_duty.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // all eight registers, then one write to an index with no register
   task automatic program_regs(input hpc_pkg::cfg_type c);
      logic [hpc_pkg::CSR_IDX_W-1:0]  idx [REG_COUNT+1];
      logic [hpc_pkg::CSR_DATA_W-1:0] val [REG_COUNT+1];
      idx[0] = hpc_pkg::CSR_TARGET;
      val[0] = with_junk(c.target_temp_mc, hpc_pkg::TARGET_W);
      idx[1] = hpc_pkg::CSR_PROP_GAIN;
      val[1] = with_junk(c.prop_gain, hpc_pkg::GAIN_W);
      idx[2] = hpc_pkg::CSR_INTEG_GAIN;
      val[2] = with_junk(c.integ_gain, hpc_pkg::GAIN_W);
      idx[3] = hpc_pkg::CSR_INTEG_LIMIT;
      val[3] = with_junk(c.integral_limit, hpc_pkg::LIMIT_W);
      idx[4] = hpc_pkg::CSR_DUTY_MIN;
      val[4] = with_junk(c.duty_min, hpc_pkg::DUTY_W);
      idx[5] = hpc_pkg::CSR_DUTY_MAX;
      val[5] = with_junk(c.duty_max, hpc_pkg::DUTY_W);
      idx[6] = hpc_pkg::CSR_DUTY_STEP;
      val[6] = with_junk(c.duty_step, hpc_pkg::DUTY_W);
      idx[7] = hpc_pkg::CSR_SMOOTH_SHIFT;
      val[7] = with_junk(c.smooth_shift, hpc_pkg::SHIFT_W);
      idx[8] = hpc_pkg::CSR_IDX_W'($urandom_range(REG_COUNT, (1 << hpc_pkg::CSR_IDX_W) - 1));
      val[8] = hpc_pkg::CSR_DATA_W'($urandom);
      for (int i = 0; i <= REG_COUNT; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      hpc_pkg::cfg_type                  c;
      int                                walk, pick;
      logic signed [hpc_pkg::TEMP_W-1:0] smp;
      logic                              ok;
      req_valid          <= 1'b0;
      req_temp_sample_mc <= '0;
      req_sample_valid   <= 1'b0;
      word_pinned        <= 1'b0;
      pinned_word        <= '0;
      csr_valid          <= 1'b0;
      csr_index          <= hpc_pkg::CSR_TARGET;
      csr_wdata          <= '0;
      reset              <= 1'b1;

      // reset settings: invalid words give all zeros, first valid sample loads the filter
      directed_rows = '{
         '{ 200000, 1'b0, 1'b1, '{0, 0, 0}},
         '{  40000, 1'b1, 1'b1, '{0, 40000, 0}},
         '{  40000, 1'b1, 1'b1, '{0, 40000, 0}},
         '{     -1, 1'b0, 1'b1, '{0, 0, 0}},
         '{      0, 1'b1, 1'b0, '{0, 0, 0}},
         '{ 200000, 1'b1, 1'b0, '{0, 0, 0}},
         '{-200000, 1'b1, 1'b0, '{0, 0, 0}},
         '{ 262143, 1'b1, 1'b0, '{0, 0, 0}},
         '{-262144, 1'b1, 1'b0, '{0, 0, 0}},
         '{-262144, 1'b0, 1'b1, '{0, 0, 0}},
         '{      0, 1'b1, 1'b0, '{0, 0, 0}},
         '{  20000, 1'b1, 1'b0, '{0, 0, 0}},
         '{  80000, 1'b1, 1'b0, '{0, 0, 0}},
         '{ 150000, 1'b1, 1'b0, '{0, 0, 0}},
         '{ -50000, 1'b1, 1'b0, '{0, 0, 0}},
         '{      1, 1'b1, 1'b0, '{0, 0, 0}},
         '{     -1, 1'b1, 1'b0, '{0, 0, 0}},
         '{  40000, 1'b1, 1'b0, '{0, 0, 0}},
         '{  40000, 1'b1, 1'b0, '{0, 0, 0}},
         '{  40000, 1'b1, 1'b0, '{0, 0, 0}},
         '{ 100000, 1'b0, 1'b1, '{0, 0, 0}},
         '{  39999, 1'b1, 1'b0, '{0, 0, 0}}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_sample(directed_rows[i].sample, directed_rows[i].ok,
                     directed_rows[i].pinned, directed_rows[i].want);
      drain_results();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: c = '{40000, 25, 2, 180000, 0, 600, 50, 2};
            // top of every range but duty_min
            1: c = '{150000, 1000, 1000, 1000000, 0, 1000, 1000, 15};
            // inverted duty window
            2: c = '{60000, 500, 100, 50000, 700, 300, 200, 1};
            // bottom of every range; duty frozen by zero step
            3: c = '{0, 0, 0, 0, 0, 0, 0, 0};
            // every bit set in target, gains, limit, duty_max and duty_step
            4: c = '{262143, 1023, 1023, 1048575, 0, 1023, 1023, 3};
            default: begin
               c.target_temp_mc = $urandom_range(150000);
               c.prop_gain      = $urandom_range(1000);
               c.integ_gain     = $urandom_range(1000);
               c.integral_limit = $urandom_range(1000000);
               c.duty_min       = $urandom_range(500);
               c.duty_max       = $urandom_range(1000, c.duty_min);
               c.duty_step      = $urandom_range(1000);
               c.smooth_shift   = $urandom_range(15);
            end
         endcase
         program_regs(c);

         if (phase < 3) begin
            tx_idle_pct = 10;
            rx_idle_pct = 53;
         end else if (phase < 6) begin
            tx_idle_pct = 53;
            rx_idle_pct = 10;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end

         walk = c.target_temp_mc;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // long response stall while samples keep coming
            if ((phase == 1 || phase == 7) && n == 60)
               holds_asked++;
            pick = $urandom_range(99);
            ok   = (pick >= 8);
            if (pick < 70) begin
               // slow drift around the setpoint, as a real plant would give
               walk = walk + int'($urandom_range(6000)) - 3000;
               if (walk > 200000) walk = 200000;
               if (walk < -200000) walk = -200000;
               smp = hpc_pkg::TEMP_W'(walk);
            end else if (pick < 92) begin
               smp = hpc_pkg::TEMP_W'(int'($urandom_range(400000)) - 200000);
            end else begin
               case ($urandom_range(3))
                  0: smp = 262143;
                  1: smp = -262144;
                  2: smp = 200000;
                  default: smp = -200000;
               endcase
            end
            send_sample(smp, ok, 1'b0, '0);
         end
         drain_results();
      end

      if (mismatches == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
